>>> hw/rtl/rfsv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfsv_pkg
// Shared constants, types and helpers of the radar frame state vote block.
// ---------------------------------------------------------------------------
package rfsv_pkg;

   localparam int NUM_STATES   = 4;
   localparam int COUNT_BITS   = 8;
   localparam int FRAME_STRIDE = 45;

   localparam int STATE_BITS  = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
   localparam int OFFSET_BITS = 6;
   localparam int CLAMP_BITS  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

   localparam logic [7:0] HDR_B0 = 8'hf4;
   localparam logic [7:0] HDR_B1 = 8'hf3;
   localparam logic [7:0] HDR_B2 = 8'hf2;
   localparam logic [7:0] HDR_B3 = 8'hf1;

   localparam logic [23:0]            HDR_LEAD     = {HDR_B0, HDR_B1, HDR_B2};
   localparam logic [OFFSET_BITS-1:0] HDR_END_OFS  = OFFSET_BITS'(3);
   localparam logic [OFFSET_BITS-1:0] STATE_OFS    = OFFSET_BITS'(8);
   localparam logic [OFFSET_BITS-1:0] FRAME_END_OFS = OFFSET_BITS'(FRAME_STRIDE - 1);
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
   localparam logic [STATE_BITS-1:0]  STATE_ALIAS  = STATE_BITS'(3);
   localparam logic [STATE_BITS-1:0]  STATE_ALIAS_TO = STATE_BITS'(1);

   // state byte handed from framer to voter
   typedef struct packed {
      logic       take;
      logic [7:0] value;
   } rfsv_state_type;

   // batch summary handed from voter to output register
   typedef struct packed {
      logic [7:0] frames_seen;
      logic [7:0] vote_count;
      logic [1:0] voted_state;
   } rfsv_result_type;

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
   endfunction

   function automatic logic [7:0] clamp8(input logic [COUNT_BITS-1:0] v);
      logic [CLAMP_BITS-1:0] w;
      w = CLAMP_BITS'(v);
      return (w > CLAMP_BITS'(255)) ? 8'hff : w[7:0];
   endfunction

endpackage

>>> hw/rtl/rfsv_framer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfsv_framer
// Header hunt and frame offset tracking; flags the state byte of each frame.
// ---------------------------------------------------------------------------
module rfsv_framer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              rx_byte,
   input  logic                    batch_end,
   output rfsv_pkg::rfsv_state_type state_hit
);

   logic [23:0]                         window_ff, window_in;
   logic                                in_frame_ff, in_frame_in;
   logic [rfsv_pkg::OFFSET_BITS-1:0]    offset_ff, offset_in;
   logic [rfsv_pkg::OFFSET_BITS-1:0]    offset_next;

   assign offset_next = offset_ff + rfsv_pkg::OFFSET_BITS'(1);

   always_comb begin
      window_in      = window_ff;
      in_frame_in    = in_frame_ff;
      offset_in      = offset_ff;
      state_hit.take  = 1'b0;
      state_hit.value = rx_byte;
      if (in_frame_ff) begin
         offset_in = offset_next;
         if (offset_next == rfsv_pkg::STATE_OFS) begin
            state_hit.take = 1'b1;
         end
         if (offset_next >= rfsv_pkg::FRAME_END_OFS) begin
            in_frame_in = 1'b0;
            window_in   = 24'd0;
            offset_in   = '0;
         end
      end else if (window_ff == rfsv_pkg::HDR_LEAD && rx_byte == rfsv_pkg::HDR_B3) begin
         in_frame_in = 1'b1;
         offset_in   = rfsv_pkg::HDR_END_OFS;
         window_in   = 24'd0;
      end else begin
         window_in = {window_ff[15:0], rx_byte};
      end
      // batch end starts the next batch hunting afresh
      if (batch_end) begin
         in_frame_in = 1'b0;
         window_in   = 24'd0;
         offset_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= 24'd0;
         in_frame_ff <= 1'b0;
         offset_ff   <= '0;
      end else if (step) begin
         window_ff   <= window_in;
         in_frame_ff <= in_frame_in;
         offset_ff   <= offset_in;
      end
   end

endmodule

>>> hw/rtl/rfsv_voter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rfsv_voter
// Saturating per-state counters with a running leader and a frame count.
// ---------------------------------------------------------------------------
module rfsv_voter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     batch_end,
   input  rfsv_pkg::rfsv_state_type  state_hit,
   output rfsv_pkg::rfsv_result_type result
);

   logic [rfsv_pkg::COUNT_BITS-1:0] counts_ff [rfsv_pkg::NUM_STATES];
   logic [rfsv_pkg::COUNT_BITS-1:0] counts_in [rfsv_pkg::NUM_STATES];
   logic [rfsv_pkg::COUNT_BITS-1:0] best_count_ff, best_count_in;
   logic [rfsv_pkg::STATE_BITS-1:0] best_state_ff, best_state_in;
   logic [rfsv_pkg::COUNT_BITS-1:0] total_ff, total_in;
   logic [rfsv_pkg::STATE_BITS-1:0] idx;
   logic [rfsv_pkg::COUNT_BITS-1:0] bumped;
   logic                            in_range;
   logic [rfsv_pkg::STATE_BITS-1:0] shown_state;

   assign idx      = state_hit.value[rfsv_pkg::STATE_BITS-1:0];
   assign in_range = state_hit.value < 8'(rfsv_pkg::NUM_STATES);
   assign bumped   = rfsv_pkg::sat_inc(counts_ff[idx]);

   always_comb begin
      for (int i = 0; i < rfsv_pkg::NUM_STATES; i++) begin
         counts_in[i] = counts_ff[i];
      end
      best_count_in = best_count_ff;
      best_state_in = best_state_ff;
      total_in      = total_ff;
      if (state_hit.take) begin
         total_in = rfsv_pkg::sat_inc(total_ff);
         if (in_range) begin
            counts_in[idx] = bumped;
            // strict compare keeps the earlier leader on a tie
            if (bumped > best_count_ff) begin
               best_count_in = bumped;
               best_state_in = idx;
            end
         end
      end
   end

   assign shown_state = (best_state_in == rfsv_pkg::STATE_ALIAS) ?
                        rfsv_pkg::STATE_ALIAS_TO : best_state_in;

   assign result.voted_state = 2'(shown_state);
   assign result.vote_count  = rfsv_pkg::clamp8(best_count_in);
   assign result.frames_seen = rfsv_pkg::clamp8(total_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rfsv_pkg::NUM_STATES; i++) begin
            counts_ff[i] <= '0;
         end
         best_count_ff <= '0;
         best_state_ff <= '0;
         total_ff      <= '0;
      end else if (step) begin
         if (batch_end) begin
            for (int i = 0; i < rfsv_pkg::NUM_STATES; i++) begin
               counts_ff[i] <= '0;
            end
            best_count_ff <= '0;
            best_state_ff <= '0;
            total_ff      <= '0;
         end else begin
            for (int i = 0; i < rfsv_pkg::NUM_STATES; i++) begin
               counts_ff[i] <= counts_in[i];
            end
            best_count_ff <= best_count_in;
            best_state_ff <= best_state_in;
            total_ff      <= total_in;
         end
      end
   end

endmodule

>>> hw/rtl/radar_frame_state_vote.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radar_frame_state_vote
// Header framer with a majority vote over radar target states per batch.
// ---------------------------------------------------------------------------
// Takes one radar byte per cycle unless stalled as below. Each byte is
// registered, then framing and vote counting act on it as it moves on; a
// batch's last byte writes one summary word into the output register. The
// summary is valid once its last byte leaves the input register. The input
// stalls only while a last byte waits and an untaken summary is held.
module radar_frame_state_vote (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte[7:0]
   input  logic        req_tlast,   // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // voted_state[1:0], vote_count[9:2],
                                    // frames_seen[17:10], zero[23:18]
);

   logic                      in_valid_ff;
   logic [7:0]                in_byte_ff;
   logic                      in_last_ff;
   logic                      go;
   logic                      rsp_valid_ff;
   rfsv_pkg::rfsv_result_type rsp_data_ff;
   rfsv_pkg::rfsv_state_type  state_hit;
   rfsv_pkg::rfsv_result_type result;

   // a last byte needs a free output slot, other bytes always proceed
   assign go         = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rfsv_framer u_framer (
      .clock     (clock),
      .reset     (reset),
      .step      (go),
      .rx_byte   (in_byte_ff),
      .batch_end (in_last_ff),
      .state_hit (state_hit)
   );

   rfsv_voter u_voter (
      .clock     (clock),
      .reset     (reset),
      .step      (go),
      .batch_end (in_last_ff),
      .state_hit (state_hit),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(go && in_last_ff))
      else $error("summary appeared without a last byte");

   a_vote_le_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[9:2] <= rsp_tdata[17:10]))
      else $error("vote count exceeds frame count");

   a_no_alias_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("state three not folded");

   a_empty_vote: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[9:2] == 8'd0) |-> (rsp_tdata[1:0] == 2'd0))
      else $error("state reported with no votes");

endmodule

>>> tb/sv/radar_frame_state_vote_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// radar_frame_state_vote_tb
// Self-checking bench for the header framer and per-batch state vote. A
// directed table covers the empty batch, the F4 F3 F2 F1 header with overlap
// and cuts, out-of-range states, tie handling and the 3-to-1 mapping. Random
// batches of well-formed frames, noise and broken frames follow, then one
// batch sent with no stalls ends on a tie. Results are checked against a
// cycle-free predictor of the framer and vote, with random stalls on both
// sides and a long output hold-off that backs the block up.
// ---------------------------------------------------------------------------
module radar_frame_state_vote_tb;

   localparam int SINK_HOLD      = 200;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_WORDS   = 1000;
   localparam int TIE_FRAMES     = 3;
   localparam int MAX_REPORTS    = 10;

   localparam logic [7:0] HDR_SEQ [4] = '{rfsv_pkg::HDR_B0, rfsv_pkg::HDR_B1,
                                          rfsv_pkg::HDR_B2, rfsv_pkg::HDR_B3};

   typedef enum logic {ROW_WORD, ROW_FRAME} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;     // byte for a single word, state byte for a frame
      logic [5:0]   stop;     // offset of the last frame byte sent
      logic         fin;
      logic         typed;
      logic [1:0]   w_state;
      logic [7:0]   w_votes;
      logic [7:0]   w_frames;
   } stim_row_type;

   localparam int NUM_ROWS = 21;
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      // empty batches right after reset, byte extremes
      '{ROW_WORD,  8'h00, 6'd0,  1'b1, 1'b1, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'hff, 6'd0,  1'b1, 1'b1, 2'd0, 8'd0, 8'd0},
      // state 3 is reported as 1
      '{ROW_FRAME, 8'h03, 6'd44, 1'b1, 1'b1, 2'd1, 8'd1, 8'd1},
      // header cut by batch end, next batch must not resume it
      '{ROW_WORD,  8'hf4, 6'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'hf3, 6'd0,  1'b1, 1'b1, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'hf2, 6'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'hf1, 6'd0,  1'b1, 1'b1, 2'd0, 8'd0, 8'd0},
      // extra lead byte before the header, out-of-range state
      '{ROW_WORD,  8'hf4, 6'd0,  1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'hff, 6'd44, 1'b1, 1'b1, 2'd0, 8'd0, 8'd1},
      // ties keep the earlier leader
      '{ROW_FRAME, 8'h02, 6'd44, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'h01, 6'd44, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'h00, 6'd44, 1'b1, 1'b1, 2'd2, 8'd1, 8'd3},
      '{ROW_FRAME, 8'h00, 6'd44, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'h03, 6'd44, 1'b0, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'h03, 6'd44, 1'b1, 1'b1, 2'd1, 8'd2, 8'd3},
      // state byte just past / exactly on the batch end
      '{ROW_FRAME, 8'h05, 6'd7,  1'b1, 1'b1, 2'd0, 8'd0, 8'd0},
      '{ROW_FRAME, 8'h02, 6'd8,  1'b1, 1'b1, 2'd2, 8'd1, 8'd1},
      '{ROW_FRAME, 8'h01, 6'd20, 1'b1, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'hf1, 6'd0,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0},
      '{ROW_WORD,  8'h80, 6'd0,  1'b1, 1'b0, 2'd0, 8'd0, 8'd0},
      // first state value past the counters
      '{ROW_FRAME, 8'h04, 6'd44, 1'b1, 1'b1, 2'd0, 8'd0, 8'd1}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte[7:0]
   logic        req_tlast = 1'b0;    // batch_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;           // voted_state[1:0], vote_count[9:2],
                                     // frames_seen[17:10], zero[23:18]

   // framer and vote tracker
   logic [23:0]                      hunt_window;
   logic                             framing;
   logic [rfsv_pkg::OFFSET_BITS-1:0] frame_pos;
   logic [rfsv_pkg::COUNT_BITS-1:0]  tally [rfsv_pkg::NUM_STATES];
   logic [rfsv_pkg::COUNT_BITS-1:0]  lead_count;
   logic [rfsv_pkg::STATE_BITS-1:0]  lead_state;
   logic [rfsv_pkg::COUNT_BITS-1:0]  frames_total;

   rfsv_pkg::rfsv_result_type vote_q [$];
   int unsigned               mismatches = 0;
   int unsigned               words_sent = 0;
   bit                        steady = 1'b0;
   bit                        hold_req = 1'b0;

   radar_frame_state_vote u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_tracker();
      hunt_window  = '0;
      framing      = 1'b0;
      frame_pos    = '0;
      lead_count   = '0;
      lead_state   = '0;
      frames_total = '0;
      foreach (tally[i]) tally[i] = '0;
   endfunction

   function automatic void track_byte(input logic [7:0] b, input logic fin,
                                      output logic has,
                                      output rfsv_pkg::rfsv_result_type res);
      logic [rfsv_pkg::STATE_BITS-1:0] idx;
      logic [rfsv_pkg::STATE_BITS-1:0] shown;
      has = 1'b0;
      res = '0;
      if (framing) begin
         frame_pos = frame_pos + 1'b1;
         if (frame_pos == rfsv_pkg::STATE_OFS) begin
            if (frames_total != rfsv_pkg::COUNT_MAX) frames_total = frames_total + 1'b1;
            if (32'(b) < rfsv_pkg::NUM_STATES) begin
               idx = b[rfsv_pkg::STATE_BITS-1:0];
               if (tally[idx] != rfsv_pkg::COUNT_MAX) tally[idx] = tally[idx] + 1'b1;
               // strictly greater, so a tie leaves the leader alone
               if (tally[idx] > lead_count) begin
                  lead_count = tally[idx];
                  lead_state = idx;
               end
            end
         end
         if (frame_pos >= rfsv_pkg::FRAME_END_OFS) begin
            framing     = 1'b0;
            hunt_window = '0;
            frame_pos   = '0;
         end
      end else if (hunt_window == rfsv_pkg::HDR_LEAD && b == rfsv_pkg::HDR_B3) begin
         framing     = 1'b1;
         frame_pos   = rfsv_pkg::HDR_END_OFS;
         hunt_window = '0;
      end else begin
         hunt_window = {hunt_window[15:0], b};
      end
      if (fin) begin
         shown = (lead_state == rfsv_pkg::STATE_ALIAS) ? rfsv_pkg::STATE_ALIAS_TO
                                                       : lead_state;
         has = 1'b1;
         res.voted_state = 2'(shown);
         res.vote_count  = (32'(lead_count) > 255) ? 8'hff : 8'(lead_count);
         res.frames_seen = (32'(frames_total) > 255) ? 8'hff : 8'(frames_total);
         clear_tracker();
      end
   endfunction

   function automatic logic [7:0] noise_byte();
      return ($urandom_range(99) < 30) ? HDR_SEQ[$urandom_range(3)] : 8'($urandom());
   endfunction

   function automatic logic [7:0] state_byte();
      return ($urandom_range(99) < 85) ? 8'($urandom_range(rfsv_pkg::NUM_STATES - 1))
                                       : 8'($urandom_range(255));
   endfunction

   // appends header, body and state byte up to offset stop; bit 8 is batch_end
   task automatic add_frame(ref logic [8:0] q [$], input logic [7:0] st, input int stop,
                            input bit rand_fill, input logic fin);
      logic [7:0] b;
      for (int k = 0; k <= stop; k++) begin
         if (k < 4) b = HDR_SEQ[k];
         else if (k == int'(rfsv_pkg::STATE_OFS)) b = st;
         else b = rand_fill ? noise_byte() : HDR_SEQ[k % 4];
         q.push_back({fin && (k == stop), b});
      end
   endtask

   task automatic send_word(input logic [7:0] b, input logic fin, input logic typed,
                            input rfsv_pkg::rfsv_result_type want);
      logic                      has;
      rfsv_pkg::rfsv_result_type res;
      while (!steady && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom());
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_byte(b, fin, has, res);
      if (has) begin
         vote_q.push_back(typed ? want : res);
      end
      words_sent++;
   endtask

   task automatic send_batch(input logic [8:0] q [$], input logic typed,
                             input rfsv_pkg::rfsv_result_type want);
      foreach (q[i]) send_word(q[i][7:0], q[i][8], typed, want);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (vote_q.size() != 0) @(posedge clock);
   endtask

   task automatic random_batch();
      logic [8:0] q [$];
      int         pick;
      pick = $urandom_range(99);
      if (pick < 25) begin
         repeat ($urandom_range(8, 1)) q.push_back({1'b0, noise_byte()});
      end else if (pick < 88) begin
         repeat ($urandom_range(3, 1)) begin
            repeat ($urandom_range(3, 0)) q.push_back({1'b0, noise_byte()});
            add_frame(q, state_byte(), rfsv_pkg::FRAME_STRIDE - 1, 1'b1, 1'b0);
         end
         repeat ($urandom_range(2, 0)) q.push_back({1'b0, noise_byte()});
      end else begin
         // frame broken off anywhere, header included
         repeat ($urandom_range(2, 0)) q.push_back({1'b0, noise_byte()});
         add_frame(q, state_byte(), $urandom_range(rfsv_pkg::FRAME_STRIDE - 1), 1'b1, 1'b0);
      end
      q[q.size() - 1][8] = 1'b1;
      send_batch(q, 1'b0, '0);
   endtask

   // result checker
   always @(posedge clock) begin
      rfsv_pkg::rfsv_result_type want;
      rfsv_pkg::rfsv_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rfsv_pkg::rfsv_result_type'(rsp_tdata[17:0]);
         if (vote_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("mismatch: unexpected result word %h", rsp_tdata);
         end else begin
            want = vote_q.pop_front();
            if (got.voted_state !== want.voted_state || got.vote_count !== want.vote_count ||
                got.frames_seen !== want.frames_seen || rsp_tdata[23:18] !== '0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"mismatch: state exp %0d got %0d, votes exp %0d got %0d, ",
                            "frames exp %0d got %0d, pad %h"},
                           want.voted_state, got.voted_state, want.vote_count,
                           got.vote_count, want.frames_seen, got.frames_seen,
                           rsp_tdata[23:18]);
            end
         end
      end
   end

   // output side: random stalls, or a long hold-off on request
   initial begin : sink
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD - 1) @(posedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 8);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      logic [8:0]   q [$];
      stim_row_type row;
      clear_tracker();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         row = DIRECTED[i];
         q = {};
         if (row.kind == ROW_WORD) q.push_back({row.fin, row.data});
         else add_frame(q, row.data, int'(row.stop), 1'b0, row.fin);
         send_batch(q, row.typed,
                    rfsv_pkg::rfsv_result_type'({row.w_frames, row.w_votes, row.w_state}));
      end
      wait_drained();

      // output held off while short batches keep coming, so the input backs up
      hold_req = 1'b1;
      repeat (30) begin
         q = {};
         repeat ($urandom_range(3, 1)) q.push_back({1'b0, noise_byte()});
         q[q.size() - 1][8] = 1'b1;
         send_batch(q, 1'b0, '0);
      end

      while (words_sent < RANDOM_WORDS) random_batch();
      wait_drained();

      // one batch with no stalls on either side, ending on a tie at the top
      steady = 1'b1;
      q = {};
      repeat (TIE_FRAMES) add_frame(q, 8'd2, rfsv_pkg::FRAME_STRIDE - 1, 1'b1, 1'b0);
      repeat (TIE_FRAMES) add_frame(q, 8'd0, rfsv_pkg::FRAME_STRIDE - 1, 1'b1, 1'b0);
      q[q.size() - 1][8] = 1'b1;
      send_batch(q, 1'b0, '0);
      wait_drained();
      steady = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && vote_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
